### rtl/tspcc_pkg.sv
// Shared types and constants for the transport stream continuity checker.
package tspcc_pkg;

   localparam int PID_BITS    = 13;
   localparam int PID_ENTRIES = 8192;

   localparam logic [7:0]          SYNC_VALUE   = 8'h47;
   localparam logic [PID_BITS-1:0] NULL_PID     = 13'h1fff;
   localparam logic [8:0]          PACKET_BYTES = 9'd188;
   localparam logic [8:0]          BASE_OFFSET  = 9'd4;
   localparam logic [8:0]          ADAPT_OFFSET = 9'd5;

   localparam logic [1:0] ADAPT_PAYLOAD_ONLY = 2'd1;
   localparam logic [1:0] ADAPT_FIELD_ONLY   = 2'd2;
   localparam logic [1:0] ADAPT_BOTH         = 2'd3;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] header_byte_one;
      logic [7:0] pid_low_byte;
      logic [7:0] control_byte;
      logic [7:0] adaptation_length;
   } req_type;

   typedef struct packed {
      logic                sync_error;
      logic [PID_BITS-1:0] packet_id;
      logic                unit_start;
      logic                carries_payload;
      logic                continuity_error;
      logic [8:0]          payload_offset;
      logic                payload_present;
      logic [31:0]         pid_packet_total;
      logic [31:0]         pid_error_total;
      logic [31:0]         sync_error_total;
   } rsp_type;

endpackage

### rtl/ts_packet_continuity_checker.sv
// Transport stream header decoder with per-PID continuity and packet counting.
// Request data is registered in s1_req_ff and the response in rsp_ff.
// Throughput: one packet per cycle while no stall holds it, same PID back to back
// included; separate PID memory read and write ports, with write forwarding,
// allow this. Reset: counters clear; a clearing pass then sweeps all 8192 PID
// memory entries one entry per cycle with req_stall held high.
module ts_packet_continuity_checker
   import tspcc_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CC_LSB     = 0;
   localparam int VALID_BIT  = 4;
   localparam int PKT_LSB    = 5;
   localparam int ERR_LSB    = PKT_LSB + COUNT_BITS;
   localparam int ENTRY_BITS = ERR_LSB + COUNT_BITS;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w[63:32] != 32'd0) ? 32'hffff_ffff : w[31:0];
   endfunction

   logic                  acc;
   logic                  store_busy;
   logic [ENTRY_BITS-1:0] rd_entry;

   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_req_ff;
   logic                  s1_adv;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0] sync_cnt_ff, sync_cnt_in;

   logic                  fwd_valid_ff;
   logic [PID_BITS-1:0]   fwd_pid_ff;
   logic [ENTRY_BITS-1:0] fwd_entry_ff;

   logic                  wr_en;
   logic [ENTRY_BITS-1:0] cur_entry, new_entry;
   logic                  sync_ok;
   logic [PID_BITS-1:0]   pid;
   logic [1:0]            adapt;
   logic [3:0]            cc, expect_cc;
   logic                  payload, check, cc_err;
   logic [COUNT_BITS-1:0] pkt_new, err_new, sync_next;
   logic [8:0]            offset;

   tspcc_pid_ram #(
      .DATA_BITS (ENTRY_BITS)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr ({req_data.header_byte_one[4:0], req_data.pid_low_byte}),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (pid),
      .wr_data (new_entry),
      .busy    (store_busy)
   );

   assign req_stall = store_busy || (s1_valid_ff && rsp_valid_ff && rsp_stall);
   assign acc       = req_valid && !req_stall;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sync_ok   = (s1_req_ff.sync_byte == SYNC_VALUE);
      pid       = {s1_req_ff.header_byte_one[4:0], s1_req_ff.pid_low_byte};
      adapt     = s1_req_ff.control_byte[5:4];
      cc        = s1_req_ff.control_byte[3:0];
      payload   = (adapt == ADAPT_PAYLOAD_ONLY) || (adapt == ADAPT_BOTH);
      check     = payload && (pid != NULL_PID);

      cur_entry = (fwd_valid_ff && (fwd_pid_ff == pid)) ? fwd_entry_ff : rd_entry;
      expect_cc = cur_entry[CC_LSB +: 4] + 4'd1;
      cc_err    = check && cur_entry[VALID_BIT] && (cc != expect_cc);
      pkt_new   = sat_inc(cur_entry[PKT_LSB +: COUNT_BITS]);
      err_new   = cc_err ? sat_inc(cur_entry[ERR_LSB +: COUNT_BITS])
                         : cur_entry[ERR_LSB +: COUNT_BITS];

      new_entry                        = cur_entry;
      new_entry[PKT_LSB +: COUNT_BITS] = pkt_new;
      new_entry[ERR_LSB +: COUNT_BITS] = err_new;
      if (check) begin
         new_entry[CC_LSB +: 4] = cc;
         new_entry[VALID_BIT]   = 1'b1;
      end

      if ((adapt == ADAPT_FIELD_ONLY) || (adapt == ADAPT_BOTH)) begin
         offset = ADAPT_OFFSET + 9'(s1_req_ff.adaptation_length);
      end else begin
         offset = BASE_OFFSET;
      end

      sync_next = sat_inc(sync_cnt_ff);
      wr_en     = s1_adv && sync_ok;

      rsp_in = '0;
      if (sync_ok) begin
         rsp_in.packet_id        = pid;
         rsp_in.unit_start       = s1_req_ff.header_byte_one[6];
         rsp_in.carries_payload  = payload;
         rsp_in.continuity_error = cc_err;
         rsp_in.payload_offset   = offset;
         rsp_in.payload_present  = payload && (offset < PACKET_BYTES);
         rsp_in.pid_packet_total = clip32(pkt_new);
         rsp_in.pid_error_total  = clip32(err_new);
         rsp_in.sync_error_total = clip32(sync_cnt_ff);
      end else begin
         rsp_in.sync_error       = 1'b1;
         rsp_in.sync_error_total = clip32(sync_next);
      end

      sync_cnt_in = (s1_adv && !sync_ok) ? sync_next : sync_cnt_ff;

      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         sync_cnt_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sync_cnt_ff  <= sync_cnt_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         fwd_pid_ff   <= pid;
         fwd_entry_ff <= new_entry;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_empty: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline active during memory clearing pass");

   a_sync_count: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !sync_ok) |=> (sync_cnt_ff != '0))
      else $error("sync error counter wrapped");

   a_cc_err_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.continuity_error) |->
         (rsp_ff.carries_payload && !rsp_ff.sync_error && (rsp_ff.packet_id != NULL_PID)
          && (rsp_ff.pid_error_total != 32'd0)))
      else $error("continuity error reported without cause");

   a_fwd_track: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (fwd_valid_ff && (fwd_pid_ff == $past(pid))))
      else $error("forwarding register missed a write");

endmodule

### rtl/tspcc_pid_ram.sv
// Per-PID state memory with a registered read port and a clearing pass after reset.
module tspcc_pid_ram
   import tspcc_pkg::*;
#(
   parameter int DATA_BITS = 69
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [PID_BITS-1:0]  rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [PID_BITS-1:0]  wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   output logic                 busy
);

   logic [DATA_BITS-1:0] mem [PID_ENTRIES];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic                 busy_ff, busy_in;
   logic [PID_BITS-1:0]  clr_addr_ff, clr_addr_in;

   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {PID_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule
